>>> src/dmxt_pkg.sv
// ----------------------------------------------------------------------------
// dmxt_pkg
// Shared types and constants of the DMX512 transmitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmxt_pkg;

  localparam int DEF_CHANNELS        = 32;
  localparam int DEF_UNIVERSE_FRAMES = 512;

  localparam int CH_W       = 5;            // width of the channel field
  localparam int ADDR_SPACE = 2 ** CH_W;    // channels the channel field can reach
  localparam int FRAME_W    = 10;           // frame index, up to 1023
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [3:0] FRAME_BITS    = 4'd11;
  localparam logic [3:0] LAST_DATA_BIT = 4'd8;

  localparam logic [2:0] MODE_WRITE = 3'd0;
  localparam logic [2:0] MODE_READ  = 3'd1;
  localparam logic [2:0] MODE_CLEAR = 3'd2;
  localparam logic [2:0] MODE_START = 3'd3;
  localparam logic [2:0] MODE_TICK  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_BREAK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAB   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD   = 2'd2;

  localparam logic [15:0] BREAK_RESET = 16'd22;
  localparam logic [17:0] MAB_RESET   = 18'd20;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BREAK,
    PH_MAB,
    PH_FRAME
  } phase_t;

  typedef struct packed {
    logic [2:0]      mode;
    logic [CH_W-1:0] channel;
    logic [7:0]      value;
    logic [15:0]     repeat_count;
  } req_t;

  typedef struct packed {
    logic       line_level;
    logic       busy_res;
    logic       status;
    logic [7:0] read_value;
    logic       read_changed;
  } rsp_t;

  typedef struct packed {
    logic [15:0] break_ticks;
    logic [17:0] mark_after_break_ticks;
    logic        pad_to_full_universe;
  } cfg_t;

  typedef struct packed {
    logic        adv;     // item in the input register completes this cycle
    logic        tick;
    logic        start;
    logic [15:0] repeat_count;
  } ser_cmd_t;

  typedef struct packed {
    logic line_level;
    logic busy;
    logic rejected;
  } ser_stat_t;

endpackage

`default_nettype wire

>>> src/dmx512_transmitter.sv
// ----------------------------------------------------------------------------
// dmx512_transmitter
// DMX512 packet transmitter with a channel byte buffer and changed flags.
// ----------------------------------------------------------------------------
//  channel | signals                      | transfer when
//  --------+------------------------------+------------------------
//  req     | req_valid, req_ready, req    | req_valid & req_ready
//  rsp     | rsp_valid, rsp_ready, rsp    | rsp_valid & rsp_ready
//  cfg     | cfg_valid, cfg_ready,        | cfg_valid & cfg_ready
//          | cfg_index, cfg_data          | (cfg_ready always high)
//
// One item per cycle sustained while rsp_ready is high; the input register
// loads at the req transfer, the result register when the item advances.
// The buffer reads are prefetched into registered RAM ports, with the last
// write forwarded.
// Reset: line at mark, idle, buffer reads zero, no clearing pass.
// A stalled rsp holds the result register; req_ready drops only when both
// registers are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmx512_transmitter import dmxt_pkg::*; #(
  parameter int CHANNELS        = DEF_CHANNELS,
  parameter int UNIVERSE_FRAMES = DEF_UNIVERSE_FRAMES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // only channels reachable by the channel field are ever stored
  localparam int STORE = (CHANNELS < ADDR_SPACE) ? CHANNELS : ADDR_SPACE;
  localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;

  cfg_t cfg;

  logic s1_valid;
  req_t s1;
  logic adv;
  logic load;
  logic [CH_W-1:0] s1_ch_next;

  logic [STORE-1:0] loaded;
  logic [STORE-1:0] changed;

  logic          wl_valid;
  logic [AW-1:0] wl_addr;
  logic [7:0]    wl_data;

  logic [AW-1:0] a;
  logic          ch_ok;
  logic          wr_en;
  logic          clear_en;
  logic          is_read;
  logic [7:0]    rd_data;
  logic [7:0]    rd_byte;

  logic [FRAME_W-1:0] fetch_next;
  logic [FRAME_W-1:0] fetch_pos;
  logic [AW-1:0]      fa;
  logic               f_ok;
  logic [7:0]         f_data;
  logic [7:0]         fetch_byte;

  ser_cmd_t  cmd;
  ser_stat_t stat;
  rsp_t      rsp_next;

  // ---------------- handshake and item registers ----------------
  assign adv       = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || adv;
  assign load      = req_valid && req_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1 <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp <= rsp_next;
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.break_ticks            <= BREAK_RESET;
      cfg.mark_after_break_ticks <= MAB_RESET;
      cfg.pad_to_full_universe   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BREAK: cfg.break_ticks            <= cfg_data[15:0];
        CFG_MAB:   cfg.mark_after_break_ticks <= cfg_data[17:0];
        CFG_PAD:   cfg.pad_to_full_universe   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // ---------------- channel buffer ----------------
  assign a        = s1.channel[AW-1:0];
  assign ch_ok    = (32'(s1.channel) < 32'(CHANNELS));
  assign wr_en    = adv && (s1.mode == MODE_WRITE) && ch_ok;
  assign clear_en = adv && (s1.mode == MODE_CLEAR);
  assign is_read  = (s1.mode == MODE_READ) && ch_ok;

  // an entry not loaded since reset or the last clear-all reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded  <= '0;
      changed <= '0;
    end else if (clear_en) begin
      loaded  <= '0;
      changed <= '1;
    end else if (wr_en) begin
      loaded[a]  <= 1'b1;
      changed[a] <= 1'b1;
    end
  end

  // RAM read data lags one write: forward it
  always_ff @(posedge clk) begin
    if (rst) begin
      wl_valid <= 1'b0;
    end else begin
      wl_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wl_addr <= a;
      wl_data <= s1.value;
    end
  end

  assign s1_ch_next = load ? req.channel : s1.channel;

  dmxt_ram #(
    .WIDTH (8),
    .DEPTH (STORE),
    .ADDR_W(AW)
  ) u_rd_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(a),
    .wdata(s1.value),
    .raddr(s1_ch_next[AW-1:0]),
    .rdata(rd_data)
  );

  dmxt_ram #(
    .WIDTH (8),
    .DEPTH (STORE),
    .ADDR_W(AW)
  ) u_fetch_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(a),
    .wdata(s1.value),
    .raddr(fetch_next[AW-1:0]),
    .rdata(f_data)
  );

  assign rd_byte = (wl_valid && (wl_addr == a)) ? wl_data : rd_data;

  assign fa   = fetch_pos[AW-1:0];
  assign f_ok = (32'(fetch_pos) < 32'(STORE));
  assign fetch_byte = (f_ok && loaded[fa]) ?
                      ((wl_valid && (wl_addr == fa)) ? wl_data : f_data) : 8'd0;

  // ---------------- serializer ----------------
  assign cmd.adv          = adv;
  assign cmd.tick         = (s1.mode == MODE_TICK);
  assign cmd.start        = (s1.mode == MODE_START);
  assign cmd.repeat_count = s1.repeat_count;

  dmxt_serializer #(
    .CHANNELS       (CHANNELS),
    .UNIVERSE_FRAMES(UNIVERSE_FRAMES)
  ) u_serializer (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .fetch_byte(fetch_byte),
    .fetch_next(fetch_next),
    .fetch_pos (fetch_pos),
    .stat      (stat)
  );

  always_comb begin
    rsp_next.line_level   = stat.line_level;
    rsp_next.busy_res     = stat.busy;
    rsp_next.status       = stat.rejected;
    rsp_next.read_value   = (is_read && loaded[a]) ? rd_byte : 8'd0;
    rsp_next.read_changed = is_read && changed[a];
  end

endmodule

`default_nettype wire

>>> src/dmxt_ram.sv
// ----------------------------------------------------------------------------
// dmxt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmxt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/dmxt_serializer.sv
// ----------------------------------------------------------------------------
// dmxt_serializer
// Packet sequencer: break, mark after break, frames, optional padding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmxt_serializer import dmxt_pkg::*; #(
  parameter int CHANNELS        = DEF_CHANNELS,
  parameter int UNIVERSE_FRAMES = DEF_UNIVERSE_FRAMES
) (
  input  logic               clk,
  input  logic               rst,
  input  ser_cmd_t           cmd,
  input  cfg_t               cfg,
  input  logic [7:0]         fetch_byte,
  output logic [FRAME_W-1:0] fetch_next,
  output logic [FRAME_W-1:0] fetch_pos,
  output ser_stat_t          stat
);

  localparam logic [FRAME_W-1:0] CH_FRAMES  = FRAME_W'(CHANNELS);
  localparam logic [FRAME_W-1:0] PAD_FRAMES = (UNIVERSE_FRAMES > CHANNELS) ?
                                              FRAME_W'(UNIVERSE_FRAMES) : FRAME_W'(CHANNELS);

  phase_t             phase, phase_next;
  logic [17:0]        tick_cnt, tick_cnt_next;
  logic [3:0]         bit_pos, bit_pos_next;
  logic [FRAME_W-1:0] frame_pos, frame_pos_next;
  logic [7:0]         shift_byte, shift_byte_next;
  logic [15:0]        packets_left, packets_left_next;
  logic               line_reg, line_reg_next;

  logic [17:0]        cnt_inc;
  logic [3:0]         bp_inc;
  logic [FRAME_W-1:0] fp_inc;
  logic [15:0]        pk_dec;
  logic [FRAME_W-1:0] frames;
  logic               level;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (cmd.adv) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_cnt     <= '0;
      bit_pos      <= '0;
      frame_pos    <= '0;
      shift_byte   <= '0;
      packets_left <= '0;
      line_reg     <= 1'b1;
      fetch_pos    <= '0;
    end else begin
      if (cmd.adv) begin
        tick_cnt     <= tick_cnt_next;
        bit_pos      <= bit_pos_next;
        frame_pos    <= frame_pos_next;
        shift_byte   <= shift_byte_next;
        packets_left <= packets_left_next;
        line_reg     <= line_reg_next;
      end
      fetch_pos <= fetch_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    tick_cnt_next     = tick_cnt;
    bit_pos_next      = bit_pos;
    frame_pos_next    = frame_pos;
    shift_byte_next   = shift_byte;
    packets_left_next = packets_left;
    line_reg_next     = line_reg;
    level             = line_reg;
    stat.rejected     = 1'b0;

    cnt_inc = tick_cnt + 18'd1;
    bp_inc  = bit_pos + 4'd1;
    fp_inc  = frame_pos + FRAME_W'(1);
    pk_dec  = packets_left - 16'd1;
    frames  = cfg.pad_to_full_universe ? PAD_FRAMES : CH_FRAMES;

    if (cmd.start) begin
      if (packets_left != 16'd0) begin
        stat.rejected = 1'b1;
      end else if (cmd.repeat_count != 16'd0) begin
        packets_left_next = cmd.repeat_count;
        phase_next        = PH_BREAK;
        tick_cnt_next     = '0;
        bit_pos_next      = '0;
        frame_pos_next    = '0;
      end
    end

    if (cmd.tick) begin
      case (phase)
        PH_BREAK: begin
          level         = 1'b0;
          line_reg_next = 1'b0;
          tick_cnt_next = cnt_inc;
          if (cnt_inc >= {2'b00, cfg.break_ticks}) begin
            phase_next    = PH_MAB;
            tick_cnt_next = '0;
          end
        end
        PH_MAB: begin
          level         = 1'b1;
          line_reg_next = 1'b1;
          tick_cnt_next = cnt_inc;
          if (cnt_inc >= cfg.mark_after_break_ticks) begin
            phase_next      = PH_FRAME;
            tick_cnt_next   = '0;
            frame_pos_next  = '0;
            shift_byte_next = fetch_byte;
            bit_pos_next    = '0;
          end
        end
        PH_FRAME: begin
          if (bit_pos == 4'd0) begin
            level = 1'b0;
          end else if (bit_pos <= LAST_DATA_BIT) begin
            level = shift_byte[3'(bit_pos - 4'd1)];
          end else begin
            level = 1'b1;
          end
          line_reg_next = level;
          bit_pos_next  = bp_inc;
          if (bp_inc >= FRAME_BITS) begin
            bit_pos_next   = '0;
            frame_pos_next = fp_inc;
            if (fp_inc >= frames) begin
              // end of packet: the line rests at space afterwards
              frame_pos_next    = '0;
              packets_left_next = pk_dec;
              line_reg_next     = 1'b0;
              if (pk_dec != 16'd0) begin
                phase_next    = PH_BREAK;
                tick_cnt_next = '0;
              end else begin
                phase_next = PH_IDLE;
              end
            end else begin
              shift_byte_next = fetch_byte;
            end
          end
        end
        default: begin
        end
      endcase
    end

    stat.line_level = level;
    stat.busy       = (packets_left_next != 16'd0);

    // next frame byte to be loaded is prefetched from the buffer
    if (!cmd.adv) begin
      fetch_next = fetch_pos;
    end else if (phase_next == PH_FRAME) begin
      fetch_next = frame_pos_next + FRAME_W'(1);
    end else begin
      fetch_next = '0;
    end
  end

endmodule

`default_nettype wire

>>> src/dmxt_checker.sv
// ----------------------------------------------------------------------------
// dmxt_checker
// Port-level checks of the DMX512 transmitter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmxt_checker import dmxt_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp
);

  // a held result stays put until its transfer
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // a rejected start only happens while packets are still pending
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> rsp.busy_res)
    else $error("start rejected while not busy");

  // nonzero bytes only come from writes, which set the changed flag
  a_read_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.read_value != 8'd0) |-> rsp.read_changed)
    else $error("nonzero channel byte without changed flag");

  // input side stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("req_ready low without output backpressure");

endmodule

bind dmx512_transmitter dmxt_checker u_dmxt_checker (
  .clk      (clk),
  .rst      (rst),
  .req_ready(req_ready),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);

`default_nettype wire
